>>> hdl/ssfm_pkg.sv
// Package for the subset sum first mask search unit.
// Holds sizes, the state type and the store word layout; no dependencies.
`timescale 1ns / 1ps

package ssfm_pkg;

    localparam int MAX_ITEMS = 15;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 8;
    localparam int MASK_W    = 15;
    localparam int WORD_W    = VAL_W + 1;

    typedef enum logic [2:0] {
        S_LOAD   = 3'b001,
        S_SEARCH = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

endpackage

>>> hdl/ssfm_ram.sv
// Generic single write, single read RAM with a registered read port.
// Stands alone; used for the item store of the search unit.
`timescale 1ns / 1ps

module ssfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

>>> hdl/subset_sum_first_mask_search_unit.sv
// Top level of the subset sum first mask search unit.
// Depends on ssfm_pkg and ssfm_ram (item store).
`timescale 1ns / 1ps

// Usage:
// Items enter on the command channel: an item is taken at a rising edge with
// start high and busy low. Each item carries a value and a flag; the item with
// i_last high also carries the target sum and the need-flagged bit, and ends
// the set. Items are stored in a 15-entry RAM, one per cycle.
// After the last item the unit walks the nonzero masks in ascending order,
// stopping at the first hit. Each mask takes one RAM read per stored item;
// the walk is bounded by the single RAM read port.
// A zero target or more than 15 items gives not found in the cycle after the
// last item is taken, without a search. busy stays high while the walk runs.
// The result is on o_found and o_mask for one cycle with o_done high; the
// receiver cannot hold it off. A new item may be taken in that same cycle.
// Reset empties the set and returns to loading; store contents stay.

module subset_sum_first_mask_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ssfm_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_flagged,
    input  logic [ssfm_pkg::VAL_W-1:0]  i_target_sum,
    input  logic                        i_need_flagged,
    input  logic                        i_last,
    output logic                        o_done,
    output logic                        o_found,
    output logic [ssfm_pkg::MASK_W-1:0] o_mask
);

    import ssfm_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [MASK_W-1:0]   r_top, n_top;
    logic [VAL_W-1:0]    r_target, n_target;
    logic                r_need, n_need;
    logic [VAL_W-1:0]    r_sum, n_sum;
    logic                r_flag, n_flag;
    logic                r_p_valid, n_p_valid;
    logic                r_p_sel, n_p_sel;
    logic                r_p_end, n_p_end;
    logic [MASK_W-1:0]   r_p_mask, n_p_mask;
    logic                r_done, n_done;
    logic                r_found, n_found;
    logic [MASK_W-1:0]   r_out_mask, n_out_mask;

    logic                w_accept;
    logic                w_room;
    logic [CNT_W-1:0]    w_count_new;
    logic                w_ovf_new;
    logic [MASK_W-1:0]   w_top_full;
    logic                w_issue_end;
    logic [WORD_W-1:0]   w_rd_data;
    logic [VAL_W-1:0]    w_acc_sum;
    logic                w_acc_flag;
    logic                w_hit;

    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < CNT_W'(MAX_ITEMS));

    ssfm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_room),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({i_flagged, i_value}),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_count_new = w_room ? (r_count + CNT_W'(1)) : r_count;
    assign w_ovf_new   = r_ovf || !w_room;
    assign w_top_full  = ~({MASK_W{1'b1}} << w_count_new);
    assign w_issue_end = (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1)));

    assign w_acc_sum  = r_sum + (r_p_sel ? w_rd_data[VAL_W-1:0] : VAL_W'(0));
    assign w_acc_flag = r_flag || (r_p_sel && w_rd_data[VAL_W]);
    assign w_hit      = (w_acc_sum == r_target) && (!r_need || w_acc_flag);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_rd_idx   = r_rd_idx;
        n_mask     = r_mask;
        n_top      = r_top;
        n_target   = r_target;
        n_need     = r_need;
        n_sum      = r_sum;
        n_flag     = r_flag;
        n_p_valid  = 1'b0;
        n_p_sel    = r_mask[r_rd_idx];
        n_p_end    = w_issue_end;
        n_p_mask   = r_mask;
        n_done     = 1'b0;
        n_found    = r_found;
        n_out_mask = r_out_mask;

        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    n_count = w_count_new;
                    n_ovf   = w_ovf_new;
                    if (i_last) begin
                        n_target = i_target_sum;
                        n_need   = i_need_flagged;
                        n_top    = w_top_full;
                        n_mask   = MASK_W'(1);
                        n_rd_idx = '0;
                        n_sum    = '0;
                        n_flag   = 1'b0;
                        n_ovf    = 1'b0;
                        if (w_ovf_new || (i_target_sum == VAL_W'(0))) begin
                            n_done     = 1'b1;
                            n_found    = 1'b0;
                            n_out_mask = '0;
                            n_count    = '0;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH, S_DRAIN: begin
                if (r_state == S_SEARCH) begin
                    n_p_valid = 1'b1;
                    if (w_issue_end) begin
                        if (r_mask == r_top) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_mask   = r_mask + MASK_W'(1);
                            n_rd_idx = '0;
                        end
                    end else begin
                        n_rd_idx = r_rd_idx + IDX_W'(1);
                    end
                end
                if (r_p_valid) begin
                    n_sum  = w_acc_sum;
                    n_flag = w_acc_flag;
                    if (r_p_end) begin
                        n_sum  = '0;
                        n_flag = 1'b0;
                        if (w_hit || (r_state == S_DRAIN)) begin
                            n_done     = 1'b1;
                            n_found    = w_hit;
                            n_out_mask = w_hit ? r_p_mask : '0;
                            n_state    = S_LOAD;
                            n_p_valid  = 1'b0;
                            n_count    = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_p_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_p_valid <= n_p_valid;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_mask     <= n_mask;
        r_top      <= n_top;
        r_target   <= n_target;
        r_need     <= n_need;
        r_sum      <= n_sum;
        r_flag     <= n_flag;
        r_p_sel    <= n_p_sel;
        r_p_end    <= n_p_end;
        r_p_mask   <= n_p_mask;
        r_found    <= n_found;
        r_out_mask <= n_out_mask;
    end

    assign o_done  = r_done;
    assign o_found = r_found;
    assign o_mask  = r_out_mask;

endmodule
